### rtl/i2c_mbe_pkg.sv
// Shared types and constants for the I2C master byte engine.
package i2c_mbe_pkg;

   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;
   localparam int ReqDataWidth = 16;
   localparam int ReqUserWidth = 4;
   localparam int RspDataWidth = 16;
   localparam logic [7:0] MsbMask = 8'h80;

   typedef enum logic [2:0] {
      OP_START     = 3'd0,
      OP_STOP      = 3'd1,
      OP_WRITE     = 3'd2,
      OP_READ      = 3'd3,
      OP_SEND_ACK  = 3'd4,
      OP_WAIT_ACK  = 3'd5
   } opcode_type;

   typedef enum logic [0:0] {
      REG_HALF_PERIOD = 1'b0,
      REG_ACK_LIMIT   = 1'b1
   } reg_index_type;

   typedef enum logic [13:0] {
      PH_IDLE = 14'b00000000000001,
      PH_ST1  = 14'b00000000000010,
      PH_ST2  = 14'b00000000000100,
      PH_SP1  = 14'b00000000001000,
      PH_SP2  = 14'b00000000010000,
      PH_AK1  = 14'b00000000100000,
      PH_AK2  = 14'b00000001000000,
      PH_WA1  = 14'b00000010000000,
      PH_WA2  = 14'b00000100000000,
      PH_WAP  = 14'b00001000000000,
      PH_WL   = 14'b00010000000000,
      PH_WH   = 14'b00100000000000,
      PH_RL   = 14'b01000000000000,
      PH_RH   = 14'b10000000000000
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  bit_count;
      logic [7:0]  shift_reg;
      logic [15:0] tick_count;
      logic [15:0] poll_count;
      logic        scl_level;
      logic        sda_level;
      logic        error_flag;
      logic [7:0]  read_hold;
   } state_type;

   typedef struct packed {
      logic [15:0] half_period_ticks;
      logic [15:0] ack_timeout_limit;
   } cfg_type;

   localparam state_type StateReset = '{
      phase:      PH_IDLE,
      bit_count:  4'd0,
      shift_reg:  8'd0,
      tick_count: 16'd0,
      poll_count: 16'd0,
      scl_level:  1'b1,
      sda_level:  1'b1,
      error_flag: 1'b0,
      read_hold:  8'd0
   };

endpackage

### rtl/i2c_mbe_csr.sv
// APB register bank holding the half period and ack timeout limit.
module i2c_mbe_csr
   import i2c_mbe_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready,
   output cfg_type                 cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;
   reg_index_type idx;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign idx = reg_index_type'(csr_paddr[2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_HALF_PERIOD: cfg_in.half_period_ticks = csr_pwdata[15:0];
            REG_ACK_LIMIT:   cfg_in.ack_timeout_limit = csr_pwdata[15:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period_ticks <= 16'd100;
         cfg_ff.ack_timeout_limit <= 16'd255;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (idx)
         REG_HALF_PERIOD: csr_prdata = {16'd0, cfg_ff.half_period_ticks};
         REG_ACK_LIMIT:   csr_prdata = {16'd0, cfg_ff.ack_timeout_limit};
         default:         csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### rtl/i2c_mbe_step.sv
// One-tick next-state logic of the SCL/SDA sequencer.
module i2c_mbe_step
   import i2c_mbe_pkg::*;
(
   input  state_type   cur,
   input  cfg_type     cfg,
   input  logic        cmd_valid,
   input  logic [2:0]  opcode,
   input  logic [7:0]  data_byte,
   input  logic        ack_bit,
   input  logic        sda_in,
   output state_type   nxt,
   output logic        cmd_done
);

   logic [15:0] pause_len;
   logic [15:0] tick_next;
   logic [3:0]  bit_next;

   assign pause_len = (cfg.half_period_ticks == 16'd0) ? 16'd1 : cfg.half_period_ticks;
   assign tick_next = (cur.tick_count != 16'd0) ? cur.tick_count - 16'd1 : 16'd0;
   assign bit_next  = cur.bit_count + 4'd1;

   function automatic state_type poll_ack(state_type s, logic sda, logic [15:0] plen);
      state_type r;
      r = s;
      if (!sda) begin
         r.scl_level = 1'b0;
         r.phase     = PH_IDLE;
      end else if (s.poll_count == 16'd0) begin
         r.error_flag = 1'b1;
         r.scl_level  = 1'b0;
         r.sda_level  = 1'b0;
         r.tick_count = plen;
         r.phase      = PH_SP1;
      end else begin
         r.poll_count = s.poll_count - 16'd1;
      end
      return r;
   endfunction

   always_comb begin
      nxt = cur;
      case (cur.phase)
         PH_IDLE: begin
            if (cmd_valid && opcode <= OP_WAIT_ACK) begin
               nxt.bit_count  = 4'd0;
               nxt.tick_count = pause_len;
               case (opcode_type'(opcode))
                  OP_START: begin
                     nxt.sda_level = 1'b1;
                     nxt.scl_level = 1'b1;
                     nxt.phase     = PH_ST1;
                  end
                  OP_STOP: begin
                     nxt.scl_level = 1'b0;
                     nxt.sda_level = 1'b0;
                     nxt.phase     = PH_SP1;
                  end
                  OP_WRITE: begin
                     nxt.scl_level = 1'b0;
                     nxt.sda_level = |(data_byte & MsbMask);
                     nxt.shift_reg = {data_byte[6:0], 1'b0};
                     nxt.phase     = PH_WL;
                  end
                  OP_READ: begin
                     nxt.sda_level = 1'b1;
                     nxt.scl_level = 1'b0;
                     nxt.shift_reg = 8'd0;
                     nxt.phase     = PH_RL;
                  end
                  OP_SEND_ACK: begin
                     nxt.sda_level = ack_bit;
                     nxt.scl_level = 1'b1;
                     nxt.phase     = PH_AK1;
                  end
                  default: begin
                     nxt.sda_level  = 1'b1;
                     nxt.error_flag = 1'b0;
                     nxt.poll_count = cfg.ack_timeout_limit;
                     nxt.phase      = PH_WA1;
                  end
               endcase
            end
         end
         PH_WAP: nxt = poll_ack(cur, sda_in, pause_len);
         default: begin
            nxt.tick_count = tick_next;
            if (tick_next == 16'd0) begin
               case (cur.phase)
                  PH_ST1: begin
                     nxt.sda_level  = 1'b0;
                     nxt.tick_count = pause_len;
                     nxt.phase      = PH_ST2;
                  end
                  PH_ST2: begin
                     nxt.scl_level = 1'b0;
                     nxt.phase     = PH_IDLE;
                  end
                  PH_SP1: begin
                     nxt.scl_level  = 1'b1;
                     nxt.sda_level  = 1'b1;
                     nxt.tick_count = pause_len;
                     nxt.phase      = PH_SP2;
                  end
                  PH_SP2: nxt.phase = PH_IDLE;
                  PH_AK1: begin
                     nxt.scl_level  = 1'b0;
                     nxt.tick_count = pause_len;
                     nxt.phase      = PH_AK2;
                  end
                  PH_AK2: nxt.phase = PH_IDLE;
                  PH_WA1: begin
                     nxt.scl_level  = 1'b1;
                     nxt.tick_count = pause_len;
                     nxt.phase      = PH_WA2;
                  end
                  PH_WA2: begin
                     nxt.phase = PH_WAP;
                     nxt = poll_ack(nxt, sda_in, pause_len);
                  end
                  PH_WL: begin
                     nxt.scl_level  = 1'b1;
                     nxt.tick_count = pause_len;
                     nxt.phase      = PH_WH;
                  end
                  PH_WH: begin
                     nxt.scl_level = 1'b0;
                     nxt.bit_count = bit_next;
                     if (bit_next >= 4'd8) begin
                        nxt.phase = PH_IDLE;
                     end else begin
                        nxt.sda_level  = |(cur.shift_reg & MsbMask);
                        nxt.shift_reg  = {cur.shift_reg[6:0], 1'b0};
                        nxt.tick_count = pause_len;
                        nxt.phase      = PH_WL;
                     end
                  end
                  PH_RL: begin
                     nxt.scl_level  = 1'b1;
                     nxt.shift_reg  = {cur.shift_reg[6:0], sda_in};
                     nxt.tick_count = pause_len;
                     nxt.phase      = PH_RH;
                  end
                  PH_RH: begin
                     nxt.scl_level = 1'b0;
                     nxt.bit_count = bit_next;
                     if (bit_next >= 4'd8) begin
                        nxt.read_hold = cur.shift_reg;
                        nxt.phase     = PH_IDLE;
                     end else begin
                        nxt.tick_count = pause_len;
                        nxt.phase      = PH_RL;
                     end
                  end
                  default: nxt.phase = PH_IDLE;
               endcase
            end
         end
      endcase
   end

   // every path into idle from a busy phase completes a command
   assign cmd_done = (cur.phase != PH_IDLE) && (nxt.phase == PH_IDLE);

endmodule

### rtl/i2c_master_byte_engine.sv
// Top level of the I2C master byte engine: input stage, sequencer state and result register.
//
// Each transfer on the req side is one clock tick of the I2C pin sequencer and yields exactly
// one transfer on the rsp side showing pin levels and status after that tick. A transfer can be
// accepted every cycle while the rsp side takes results. The tick is held in the input register
// and is then computed into the result register, which drives rsp_tvalid. The rate is set only
// by the rsp side taking results from the result register. SCL and SDA pauses are counted in
// ticks, so the bus speed follows the rate of req transfers and half_period_ticks.
module i2c_master_byte_engine
   import i2c_mbe_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [ReqDataWidth-1:0] req_tdata,   // data_byte[7:0], ack_bit, sda_in, zero pad
   input  logic [ReqUserWidth-1:0] req_tuser,   // cmd_valid, opcode[2:0]
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata,   // scl_release, sda_release, busy_res,
                                                // cmd_done, read_data[7:0], ack_timeout, pad
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready
);

   cfg_type   cfg;
   state_type st_ff, st_in;
   logic      s1_valid_ff, s1_valid_in;
   logic [ReqDataWidth-1:0] s1_data_ff;
   logic [ReqUserWidth-1:0] s1_user_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [RspDataWidth-1:0] rsp_data_ff, rsp_data_in;
   logic      advance;
   logic      done;

   i2c_mbe_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   i2c_mbe_step u_step (
      .cur       (st_ff),
      .cfg       (cfg),
      .cmd_valid (s1_user_ff[0]),
      .opcode    (s1_user_ff[3:1]),
      .data_byte (s1_data_ff[7:0]),
      .ack_bit   (s1_data_ff[8]),
      .sda_in    (s1_data_ff[9]),
      .nxt       (st_in),
      .cmd_done  (done)
   );

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_tvalid && req_tready) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_data_in = {3'd0, st_in.error_flag, st_in.read_hold, done,
                         (st_in.phase != PH_IDLE), st_in.sda_level, st_in.scl_level};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         st_ff        <= StateReset;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            st_ff <= st_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_data_ff <= req_tdata;
         s1_user_ff <= req_tuser;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_reset_empties: assert property (@(posedge clock)
      reset |=> (!s1_valid_ff && !rsp_valid_ff))
      else $error("pipeline not empty after reset");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(req_tvalid && req_tready && s1_valid_ff && !advance))
      else $error("input stage overwritten");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[3]) |-> !rsp_tdata[2])
      else $error("done reported while busy");

   a_bit_count_range: assert property (@(posedge clock) disable iff (reset)
      st_ff.bit_count <= 4'd8)
      else $error("bit counter out of range");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      (!$past(advance) && !$past(reset)) |-> $stable(st_ff))
      else $error("sequencer state changed without a tick");
`endif

endmodule
